/* hw/rtl/matrix_multiply_macros.svh */
// ----------------------------------------------------------------------------
// matrix_multiply assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix_multiply: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix_multiply: next-cycle check failed");

`endif

/* hw/rtl/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// Widths, codes, types and helpers shared by the matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  // Sizing
  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int CNT_W     = $clog2(MAX_DIM + 1);
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PROD_W    = 2 * WORD_W;
  localparam int ACC_W     = PROD_W + $clog2(MAX_DIM);

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Saturation limits
  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_ISSUE,
    ST_DRAIN
  } mm_state_t;

  // Raw dimension registers
  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] inner;
    logic [CFG_W-1:0] cols;
  } mm_dims_t;

  // Store write request
  typedef struct packed {
    logic              en_a;
    logic              en_b;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mm_wr_t;

  // Store read addresses
  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } mm_rd_t;

  // Tag that follows one product through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm_tag_t;

  // Result register load from the sequencer
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } mm_emit_t;

  // Finished element from the MAC
  typedef struct packed {
    logic [WORD_W-1:0] product;
    logic              saturated;
  } mm_res_t;

  // Zero acts as one, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [CNT_W-1:0] res;
    if (d == '0) begin
      res = CNT_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      res = CNT_W'(MAX_DIM);
    end else begin
      res = CNT_W'(d);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/mm_if.sv */
// ----------------------------------------------------------------------------
// mm_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------

// Request channel: element loads and compute commands
interface mm_in_if;
  import mm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, func, row, col, value, input ready);
  modport sink   (input valid, func, row, col, value, output ready);
endinterface

// Result channel: one element of C per transfer
interface mm_out_if;
  import mm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [WORD_W-1:0] product;
  logic                     saturated;
  logic                     last;

  modport source (output valid, out_row, out_col, product, saturated, last, input ready);
  modport sink   (input valid, out_row, out_col, product, saturated, last, output ready);
endinterface

// Configuration write channel
interface mm_cfg_if;
  import mm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/mm_store.sv */
// ----------------------------------------------------------------------------
// mm_store
// Element memories for A and B: one write port, one registered read each.
// ----------------------------------------------------------------------------
module mm_store (
  input  logic                             clk,
  input  mm_pkg::mm_wr_t                   wr,
  input  logic                             rd_en,
  input  mm_pkg::mm_rd_t                   rd,
  output logic signed [mm_pkg::WORD_W-1:0] a_data,
  output logic signed [mm_pkg::WORD_W-1:0] b_data
);
  import mm_pkg::*;

  logic [WORD_W-1:0] a_mem [DEPTH];
  logic [WORD_W-1:0] b_mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en_a) begin
      a_mem[wr.addr] <= wr.data;
    end
    if (wr.en_b) begin
      b_mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_data <= a_mem[rd.addr_a];
      b_data <= b_mem[rd.addr_b];
    end
  end

endmodule

/* hw/rtl/mm_mac.sv */
// ----------------------------------------------------------------------------
// mm_mac
// Shared multiply-accumulate unit with Q16.16 rescale and saturation.
// ----------------------------------------------------------------------------
module mm_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mm_pkg::mm_tag_t                  tag,
  input  logic signed [mm_pkg::WORD_W-1:0] a_data,
  input  logic signed [mm_pkg::WORD_W-1:0] b_data,
  output logic                             done,
  output mm_pkg::mm_res_t                  res
);
  import mm_pkg::*;

  mm_tag_t                  s1_tag_r;
  mm_tag_t                  s2_tag_r;
  logic                     done_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-WORD_W:0]    hi_bits;
  logic                     fits;

  // Tag pipeline: aligned with read data (s1) and product (s2)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      done_r   <= 1'b0;
    end else begin
      s1_tag_r <= tag;
      s2_tag_r <= s1_tag_r;
      done_r   <= s2_tag_r.valid && s2_tag_r.last;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Accumulate stage, restarted on the first term of each element
  always_ff @(posedge clk) begin
    if (s2_tag_r.valid) begin
      if (s2_tag_r.first) begin
        acc_r <= prod_ext;
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
  end

  // Rescale (floor) and clamp to 32 bits
  assign shifted = acc_r >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:WORD_W-1];
  assign fits    = (&hi_bits) || (~|hi_bits);

  always_comb begin
    res.saturated = !fits;
    if (fits) begin
      res.product = shifted[WORD_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      res.product = SAT_MIN;
    end else begin
      res.product = SAT_MAX;
    end
  end

  assign done = done_r;

endmodule

/* hw/rtl/mm_seq.sv */
// ----------------------------------------------------------------------------
// mm_seq
// Sequencer: takes requests, writes the stores and walks C element by
// element, feeding one A/B pair per cycle to the MAC while it issues terms.
// ----------------------------------------------------------------------------
module mm_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [mm_pkg::FUNC_W-1:0]        in_func,
  input  logic [mm_pkg::IDX_W-1:0]         in_row,
  input  logic [mm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mm_pkg::WORD_W-1:0] in_value,
  output logic                             in_ready,
  input  mm_pkg::mm_dims_t                 dims,
  input  logic                             out_busy,
  input  logic                             mac_done,
  output mm_pkg::mm_wr_t                   wr,
  output mm_pkg::mm_rd_t                   rd,
  output mm_pkg::mm_tag_t                  tag,
  output mm_pkg::mm_emit_t                 emit
);
  import mm_pkg::*;

  mm_state_t        state_r, state_nxt;
  logic [DIM_W-1:0] r_r, r_nxt;
  logic [DIM_W-1:0] c_r, c_nxt;
  logic [DIM_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] nr_r, nr_nxt;
  logic [CNT_W-1:0] nk_r, nk_nxt;
  logic [CNT_W-1:0] nc_r, nc_nxt;
  logic             in_range;
  logic             last_k;
  logic             last_c;
  logic             last_r;

  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign last_k   = (CNT_W'(k_r) == nk_r - CNT_W'(1));
  assign last_c   = (CNT_W'(c_r) == nc_r - CNT_W'(1));
  assign last_r   = (CNT_W'(r_r) == nr_r - CNT_W'(1));

  // Read addresses: A[r][k] and B[k][c]
  assign rd.addr_a = ADDR_W'(r_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r);
  assign rd.addr_b = ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(c_r);

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
      nr_r    <= CNT_W'(1);
      nk_r    <= CNT_W'(1);
      nc_r    <= CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      nr_r    <= nr_nxt;
      nk_r    <= nk_nxt;
      nc_r    <= nc_nxt;
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    nr_nxt    = nr_r;
    nk_nxt    = nk_r;
    nc_nxt    = nc_r;
    in_ready  = 1'b0;
    wr.en_a   = 1'b0;
    wr.en_b   = 1'b0;
    wr.addr   = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
    wr.data   = in_value;
    tag       = '0;
    emit.load = 1'b0;
    emit.row  = IDX_W'(r_r);
    emit.col  = IDX_W'(c_r);
    emit.last = last_r && last_c;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            FUNC_WR_A: wr.en_a = in_range;
            FUNC_WR_B: wr.en_b = in_range;
            FUNC_COMPUTE: begin
              nr_nxt    = clamp_dim(dims.rows);
              nk_nxt    = clamp_dim(dims.inner);
              nc_nxt    = clamp_dim(dims.cols);
              r_nxt     = '0;
              c_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_WAIT;
            end
            default: ;
          endcase
        end
      end

      // Hold off until the result register is free
      ST_WAIT: begin
        if (!out_busy) begin
          state_nxt = ST_ISSUE;
        end
      end

      // One product term per cycle
      ST_ISSUE: begin
        tag.valid = 1'b1;
        tag.first = (k_r == '0);
        tag.last  = last_k;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
      end

      // Wait for the sum, load the result, step to the next element
      ST_DRAIN: begin
        if (mac_done) begin
          emit.load = 1'b1;
          if (last_r && last_c) begin
            state_nxt = ST_IDLE;
          end else if (last_c) begin
            c_nxt     = '0;
            r_nxt     = r_r + DIM_W'(1);
            state_nxt = ST_WAIT;
          end else begin
            c_nxt     = c_r + DIM_W'(1);
            state_nxt = ST_WAIT;
          end
        end
      end
    endcase
  end

endmodule

/* hw/rtl/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_multiply
// Signed Q16.16 matrix product C = A x B over stored element memories.
// ----------------------------------------------------------------------------
// A load request (write A or B element) gives no result. A compute request
// walks C in row-major order with one shared 32x32 multiply-accumulate unit
// that reads one A and one B word per cycle while issuing an element's terms.
// Each element's reads start only after the previous result has left the
// output register. in_ch.ready stays low from the compute request until the
// last element has been loaded into the output register. Sums are floored by
// the fractional shift and clamped to 32 bits, with saturated set on clamping.
module matrix_multiply (
  input  logic     clk,
  input  logic     rst_n,
  mm_in_if.sink    in_ch,
  mm_out_if.source out_ch,
  mm_cfg_if.sink   cfg_ch
);
  import mm_pkg::*;

  mm_dims_t                 dims_r;
  mm_wr_t                   wr;
  mm_rd_t                   rd;
  mm_tag_t                  tag;
  mm_emit_t                 emit;
  mm_res_t                  res;
  logic                     mac_done;
  logic signed [WORD_W-1:0] a_data;
  logic signed [WORD_W-1:0] b_data;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [IDX_W-1:0]         out_col_r;
  logic [WORD_W-1:0]        product_r;
  logic                     saturated_r;
  logic                     last_r;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows  <= CFG_RESET;
      dims_r.inner <= CFG_RESET;
      dims_r.cols  <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ROWS_A:    dims_r.rows  <= cfg_ch.data;
        CFG_INNER_DIM: dims_r.inner <= cfg_ch.data;
        CFG_COLS_B:    dims_r.cols  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  mm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_row   (in_ch.row),
    .in_col   (in_ch.col),
    .in_value (in_ch.value),
    .in_ready (in_ch.ready),
    .dims     (dims_r),
    .out_busy (out_valid_r),
    .mac_done (mac_done),
    .wr       (wr),
    .rd       (rd),
    .tag      (tag),
    .emit     (emit)
  );

  mm_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (tag.valid),
    .rd     (rd),
    .a_data (a_data),
    .b_data (b_data)
  );

  mm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag    (tag),
    .a_data (a_data),
    .b_data (b_data),
    .done   (mac_done),
    .res    (res)
  );

  // Output register: loaded only when empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_row_r   <= emit.row;
      out_col_r   <= emit.col;
      product_r   <= res.product;
      saturated_r <= res.saturated;
      last_r      <= emit.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.product   = product_r;
  assign out_ch.saturated = saturated_r;
  assign out_ch.last      = last_r;

endmodule

/* hw/rtl/mm_checker.sv */
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks for matrix_multiply, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_multiply_macros.svh"

module mm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [mm_pkg::FUNC_W-1:0] in_func,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [mm_pkg::WORD_W-1:0] out_product,
  input logic                      out_saturated,
  input logic                      out_last
);
  import mm_pkg::*;

  // A stalled result stays offered
  `MM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result keeps its payload
  `MM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_product) && $stable(out_last))

  // A compute request closes the request side
  `MM_ASSERT_NEXT(a_compute_busy, in_valid && in_ready && (in_func == FUNC_COMPUTE), !in_ready)

  // An idle block with an empty result side cannot produce a result next cycle
  `MM_ASSERT_NEXT(a_idle_quiet, in_ready && !out_valid, !out_valid)

  // A clamped element is one of the two limits
  `MM_ASSERT_SAME(a_sat_value, out_valid && out_saturated, (out_product == SAT_MAX) || (out_product == SAT_MIN))

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_func       (in_ch.func),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_product   (out_ch.product),
  .out_saturated (out_ch.saturated),
  .out_last      (out_ch.last)
);
